[rtl/arpc_pkg.sv]
package arpc_pkg;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_LOOKUP = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_PURGE  = 3'd3,
    KIND_AGE    = 3'd4
  } kind_e;

  localparam logic [31:0] NO_AGE_MARK = 32'hFFFF_FFFF;
  localparam logic [31:0] TTL_RESET   = 32'd60000;
  localparam int unsigned COUNT_MAX   = 31;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [47:0] mac_out;
    logic [4:0]  removed_count;
  } rsp_t;

endpackage

[rtl/arpc_req_if.sv]
interface arpc_req_if;
  logic             valid;
  logic             ready;
  arpc_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/arpc_rsp_if.sv]
interface arpc_rsp_if;
  logic             valid;
  logic             ready;
  arpc_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/arpc_front.sv]
module arpc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  arpc_req_if.sink       req,
  input  logic           q_ready_i,
  output logic           q_valid_o,
  output arpc_pkg::req_t q_data_o
);
  // two-entry queue between front and back
  arpc_pkg::req_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign req.ready = (cnt_q != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= req.data;
  end
endmodule

[rtl/arpc_back.sv]
module arpc_back #(
  parameter int CacheEntries = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    ttl_i,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  arpc_pkg::req_t q_data_i,
  arpc_rsp_if.source     rsp
);
  localparam int IW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int CW = $clog2(CacheEntries + 1);
  localparam int NP = 1 << IW;

  function automatic logic [4:0] clip(input logic [CW-1:0] n);
    if (32'(n) > arpc_pkg::COUNT_MAX) clip = 5'(arpc_pkg::COUNT_MAX);
    else clip = 5'(n);
  endfunction

  logic [CacheEntries-1:0] val_q;
  logic [31:0] ip_q    [CacheEntries];
  logic [47:0] mac_q   [CacheEntries];
  logic [31:0] stamp_q [CacheEntries];
  logic [31:0] last_q  [CacheEntries];

  // stage 1: match and classify, registered
  logic                    s1_q;
  arpc_pkg::req_t          r_q;
  logic [CacheEntries-1:0] hit_q, free_q, old_q;
  logic                    busy;

  logic [CacheEntries-1:0] hit_d, free_d, old_d;
  always_comb begin
    for (int i = 0; i < CacheEntries; i++) begin
      hit_d[i]  = val_q[i] && (ip_q[i] == q_data_i.ip_addr);
      free_d[i] = !val_q[i];
      old_d[i]  = val_q[i] && ((q_data_i.now_ms - stamp_q[i]) > ttl_i);
    end
  end

  assign busy      = s1_q || (rsp.valid && !rsp.ready);
  assign q_ready_o = !busy;

  // stage 2: lowest-index selection and victim search
  logic [IW-1:0] hit_idx, free_idx, lru_idx;
  logic          any_hit, any_free;
  logic [CW-1:0] n_purge, n_age;
  always_comb begin
    hit_idx = '0; free_idx = '0;
    any_hit = 1'b0; any_free = 1'b0;
    n_purge = '0; n_age = '0;
    for (int i = CacheEntries - 1; i >= 0; i--) begin
      if (hit_q[i]) begin hit_idx = IW'(i); any_hit = 1'b1; end
      if (free_q[i]) begin free_idx = IW'(i); any_free = 1'b1; end
    end
    for (int i = 0; i < CacheEntries; i++) begin
      n_purge = n_purge + CW'(val_q[i]);
      n_age   = n_age + CW'(old_q[i]);
    end
  end

  // oldest last-use as a compare tree, ties go to the lower index
  logic [31:0]   lru_val [2*NP];
  logic [IW-1:0] lru_sel [2*NP];
  always_comb begin
    for (int k = 0; k < 2 * NP; k++) begin
      lru_val[k] = arpc_pkg::NO_AGE_MARK;
      lru_sel[k] = '0;
    end
    for (int i = 0; i < NP; i++) lru_sel[NP + i] = IW'(i);
    for (int i = 0; i < CacheEntries; i++) lru_val[NP + i] = last_q[i];
    for (int k = NP - 1; k >= 1; k--) begin
      if (lru_val[2*k+1] < lru_val[2*k]) begin
        lru_val[k] = lru_val[2*k+1];
        lru_sel[k] = lru_sel[2*k+1];
      end else begin
        lru_val[k] = lru_val[2*k];
        lru_sel[k] = lru_sel[2*k];
      end
    end
  end
  assign lru_idx = lru_sel[1];

  logic [IW-1:0] add_idx;
  assign add_idx = any_hit ? hit_idx : (any_free ? free_idx : lru_idx);

  arpc_pkg::rsp_t rsp_d;
  always_comb begin
    rsp_d = '0;
    unique case (r_q.kind)
      arpc_pkg::KIND_LOOKUP: begin
        if (any_hit) begin
          rsp_d.found   = 1'b1;
          rsp_d.mac_out = mac_q[hit_idx];
        end
      end
      arpc_pkg::KIND_REMOVE: begin
        if (any_hit) rsp_d.found = 1'b1;
      end
      arpc_pkg::KIND_PURGE: rsp_d.removed_count = clip(n_purge);
      arpc_pkg::KIND_AGE:   rsp_d.removed_count = clip(n_age);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= 1'b0;
      r_q       <= '0;
      hit_q     <= '0;
      free_q    <= '0;
      old_q     <= '0;
      rsp.valid <= 1'b0;
      rsp.data  <= '0;
      val_q     <= '0;
      for (int i = 0; i < CacheEntries; i++) begin
        ip_q[i] <= '0; mac_q[i] <= '0; stamp_q[i] <= '0; last_q[i] <= '0;
      end
    end else begin
      if (q_valid_i && q_ready_o) begin
        s1_q   <= 1'b1;
        r_q    <= q_data_i;
        hit_q  <= hit_d;
        free_q <= free_d;
        old_q  <= old_d;
      end else if (s1_q) begin
        s1_q <= 1'b0;
      end
      if (s1_q) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
      if (s1_q) begin
        rsp.data <= rsp_d;
        unique case (r_q.kind)
          arpc_pkg::KIND_ADD: begin
            if (r_q.ip_addr != '0) begin
              ip_q[add_idx]    <= r_q.ip_addr;
              mac_q[add_idx]   <= r_q.mac_addr;
              stamp_q[add_idx] <= r_q.now_ms;
              last_q[add_idx]  <= r_q.now_ms;
              val_q[add_idx]   <= 1'b1;
            end
          end
          arpc_pkg::KIND_LOOKUP: begin
            if (any_hit) last_q[hit_idx] <= r_q.now_ms;
          end
          arpc_pkg::KIND_REMOVE: begin
            if (any_hit) begin
              val_q[hit_idx] <= 1'b0;
              ip_q[hit_idx]  <= '0;
            end
          end
          arpc_pkg::KIND_PURGE: begin
            for (int i = 0; i < CacheEntries; i++) begin
              val_q[i] <= 1'b0;
              if (val_q[i]) ip_q[i] <= '0;
            end
          end
          arpc_pkg::KIND_AGE: begin
            for (int i = 0; i < CacheEntries; i++) begin
              if (old_q[i]) begin val_q[i] <= 1'b0; ip_q[i] <= '0; end
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule

[rtl/arp_cache_lru_aging_top.sv]
// channel | dir | payload
// req     | in  | kind, ip_addr, mac_addr, now_ms
// rsp     | out | found, mac_out, removed_count
// in the back end a request is matched and classified, then selected and written back
// a two-entry queue decouples acceptance; the back end holds one request at a time
// one result register; a stalled result blocks the next request in the back end
// reset clears all entries and sets the ttl to 60000
module arp_cache_lru_aging_top #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  arpc_req_if.sink    req,
  arpc_rsp_if.source  rsp
);
  logic [31:0]    ttl_q;
  logic           q_valid, q_ready;
  arpc_pkg::req_t q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ttl_q <= arpc_pkg::TTL_RESET;
    else if (cfg_we_i) ttl_q <= cfg_wdata_i;
  end

  arpc_front u_front (
    .clk_i, .rst_ni, .req,
    .q_ready_i(q_ready), .q_valid_o(q_valid), .q_data_o(q_data)
  );

  arpc_back #(.CacheEntries(CACHE_ENTRIES)) u_back (
    .clk_i, .rst_ni, .ttl_i(ttl_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data), .rsp
  );

  a_found_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.data.found |-> rsp.data.removed_count == 5'd0)
    else $error("found with count");
  a_mac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.data.found |-> rsp.data.mac_out == 48'd0)
    else $error("mac without hit");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result dropped");
endmodule
